// File: hdl/fir_pkg.sv
// Package for the Q15 direct-form FIR filter.
// Holds sizes, the coefficient table with its rescaling, and the sequencer states.
// No dependencies.
package fir_pkg;

  localparam int TAPS           = 13;
  localparam int SAMPLE_BITS    = 12;
  localparam int COEF_FRAC_BITS = 15;

  localparam int NCOEF  = 13;
  localparam int COEF_W = 16;
  localparam int OUT_W  = 16;
  localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PROD_W = COEF_W + SAMPLE_BITS + 1;
  localparam int ACC_W  = PROD_W + $clog2(TAPS + 1);

  localparam logic signed [COEF_W-1:0] COEF_Q15 [NCOEF] = '{
    16'sd3163, -16'sd513, -16'sd1642, -16'sd3217, -16'sd4828, -16'sd6026, 16'sd26299,
    -16'sd6026, -16'sd4828, -16'sd3217, -16'sd1642, -16'sd513, 16'sd3163
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } fir_state_t;

  // Coefficient of tap k in Q(COEF_FRAC_BITS), rounded half up; zero past the table.
  function automatic logic signed [COEF_W-1:0] coef_at(input int k);
    logic signed [COEF_W+1:0] c;
    logic signed [COEF_W+1:0] r;
    c = '0;
    r = '0;
    if (k < NCOEF) begin
      c = (COEF_W+2)'(COEF_Q15[k]);
      if (COEF_FRAC_BITS >= 15) begin
        r = c;
      end else begin
        r = (c + ((COEF_W+2)'(1) <<< (14 - COEF_FRAC_BITS))) >>> (15 - COEF_FRAC_BITS);
      end
    end
    return r[COEF_W-1:0];
  endfunction

endpackage

// File: hdl/fir_filter_q15.sv
// Top level of the Q15 direct-form FIR filter: delay line, one shared MAC, sequencer.
// Depends on fir_pkg for sizes, coefficients and state encoding.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------
//  input    | in_valid / in_stall   | sample (12 bits, unsigned)
//  output   | out_valid / out_stall | filtered_value (16 bits, signed)
//
// From acceptance to its result an item passes through these steps in order: the
// accept step, one multiply per tap through the single shared multiplier, a step
// to add the last product, and a step to shift, saturate and load.
// in_stall is high from acceptance until the result is loaded into the output register.
// A result held by out_stall keeps the next item waiting in its last step.
// Synchronous reset clears the delay line, write pointer and valid flags.
module fir_filter_q15
  import fir_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] filtered_value
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Q_MIN = -ACC_W'(32768);

  fir_state_t state;
  fir_state_t state_next;

  logic [SAMPLE_BITS-1:0]   delay_line [TAPS];
  logic [IDX_W-1:0]         write_pointer;
  logic [IDX_W-1:0]         rd;
  logic [IDX_W-1:0]         k;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  q;
  logic signed [OUT_W-1:0]  sat;
  logic                     accept;
  logic                     load_out;

  // Shift and saturate the finished sum
  always_comb begin
    q = acc >>> COEF_FRAC_BITS;
    priority if (q > Q_MAX) begin
      sat = OUT_W'(Q_MAX);
    end else if (q < Q_MIN) begin
      sat = OUT_W'(Q_MIN);
    end else begin
      sat = q[OUT_W-1:0];
    end
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence: take an item, run the taps, drain, deliver
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    accept     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (k == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Write the new item into the delay line and advance the write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        delay_line[i] <= '0;
      end
      write_pointer <= '0;
    end else if (accept) begin
      delay_line[write_pointer] <= sample;
      write_pointer <= (write_pointer == LAST_IDX) ? '0 : write_pointer + 1'b1;
    end
  end

  // Run the shared multiplier and accumulator, newest sample first
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          rd         <= write_pointer;
          k          <= '0;
          acc        <= '0;
          prod_valid <= 1'b0;
        end
        ST_MAC: begin
          prod       <= PROD_W'(coef_at(int'(k)) * $signed({1'b0, delay_line[rd]}));
          prod_valid <= 1'b1;
          if (prod_valid) begin
            acc <= acc + ACC_W'(prod);
          end
          k  <= k + 1'b1;
          rd <= (rd == '0) ? LAST_IDX : rd - 1'b1;
        end
        ST_DRAIN: begin
          acc        <= acc + ACC_W'(prod);
          prod_valid <= 1'b0;
        end
        ST_DONE: begin
          prod_valid <= 1'b0;
        end
        default: begin
          prod_valid <= 1'b0;
        end
      endcase
    end
  end

  // Hold the result until the output side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered_value <= sat;
    end
  end

endmodule
